// ----- rtl/tbsa_pkg.sv -----
package tbsa_pkg;

  localparam int CHANNELS = 8;
  localparam int BINS     = 1024;
  localparam int CH_W     = 3;
  localparam int BIN_W    = 10;
  localparam int ADDR_W   = CH_W + BIN_W;
  localparam int DEPTH    = CHANNELS * BINS;

  localparam logic [25:0] CNT_MAX = 26'h3FFFFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RPB    = 2'd0;
  localparam logic [1:0] CFG_MINUTE = 2'd1;
  localparam logic [1:0] CFG_BINS   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  typedef struct packed {
    logic               command;
    logic [2:0]         channel;
    logic signed [31:0] time_offset;
    logic [9:0]         bin_index;
    logic [15:0]        count_in;
    logic signed [23:0] mean_in;
    logic [23:0]        rms_in;
    logic signed [23:0] min_in;
    logic signed [23:0] max_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [25:0]        bin_time;
    logic [25:0]        sample_count;
    logic signed [23:0] mean_out;
    logic [23:0]        std_dev_out;
    logic signed [23:0] minimum_out;
    logic signed [23:0] maximum_out;
    logic               any_data;
  } out_item_t;

  typedef struct packed {
    logic [25:0]        cnt;
    logic signed [63:0] wsum;
    logic [63:0]        sqsum;
    logic signed [23:0] mn;
    logic signed [23:0] mx;
  } entry_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_BDIV, S_BWAIT, S_ACHK, S_AM1W, S_AM2W,
    S_RCHK, S_RCLR, S_RMAW, S_RMBW, S_RMDW, S_RSDW, S_RSQW,
    S_FIN_ACC, S_FIN_DROP, S_FIN_READ
  } state_t;

  typedef enum logic [1:0] {DIV_BIN, DIV_MEAN, DIV_SD} div_sel_t;
  typedef enum logic [1:0] {MUL_RR, MUL_RRN, MUL_SQN, MUL_SS} mul_sel_t;
  typedef enum logic [1:0] {SD_ZERO, SD_SAT, SD_ROOT} sd_sel_t;

  typedef struct packed {
    logic       clr_step;
    logic       capture;
    logic       div_start;
    div_sel_t   div_sel;
    logic       mul_start;
    mul_sel_t   mul_sel;
    logic       p_ld;
    logic       mem_rd;
    logic       wr_acc;
    logic       wr_zero;
    logic       a_ld;
    logic       num_ld;
    logic       mean_ld;
    logic       sd_ld;
    sd_sel_t    sd_sel;
    logic       sqrt_start;
    logic       out_load;
    logic [1:0] out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_busy;
    logic mul_busy;
    logic sqrt_busy;
    logic in_range;
    logic rd_ok;
    logic n_lt2;
    logic sd_sat;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/tbsa_mul.sv -----
module tbsa_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a_in,
  input  logic [63:0]  b_in,
  output logic         busy,
  output logic [127:0] prod
);

  logic [63:0]  a;
  logic [63:0]  b;
  logic [63:0]  pp;
  logic [1:0]   pw;
  logic [2:0]   step;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [127:0] pp_sh;

  // One 32x32 partial product per cycle; each is added in the cycle after it is formed.
  assign a_part = step[1] ? a[63:32] : a[31:0];
  assign b_part = step[0] ? b[63:32] : b[31:0];

  always_comb begin
    case (pw)
      2'd0:    pp_sh = {64'b0, pp};
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      2'd2:    pp_sh = {pp, 64'b0};
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd4) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= a_in;
      b    <= b_in;
      prod <= '0;
    end else if (busy) begin
      if (step != 3'd4) begin
        pp <= a_part * b_part;
        pw <= 2'({1'b0, step[1]} + {1'b0, step[0]});
      end
      if (step != 3'd0) begin
        prod <= prod + pp_sh;
      end
    end
  end

endmodule

// ----- rtl/tbsa_div.sv -----
module tbsa_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [51:0] rem0,
  input  logic [63:0] dvd0,
  input  logic [51:0] dvs_in,
  input  logic [6:0]  iters,
  output logic        busy,
  output logic [63:0] quo
);

  logic [51:0] rem;
  logic [63:0] dvd;
  logic [51:0] dvs;
  logic [6:0]  cnt;
  logic [52:0] trial;
  logic        ge;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, dvd[63]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem0;
      dvd <= dvd0;
      dvs <= dvs_in;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? 52'(trial - {1'b0, dvs}) : trial[51:0];
      quo <= {quo[62:0], ge};
      dvd <= {dvd[62:0], 1'b0};
    end
  end

endmodule

// ----- rtl/tbsa_dp.sv -----
module tbsa_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  tbsa_pkg::ctrl_cmd_t  cmd,
  output tbsa_pkg::dp_stat_t   st,
  input  tbsa_pkg::in_item_t   in_item,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output tbsa_pkg::out_item_t  out_item
);

  tbsa_pkg::entry_t    mem [tbsa_pkg::DEPTH];
  tbsa_pkg::entry_t    rdata;
  tbsa_pkg::entry_t    wdata;
  tbsa_pkg::entry_t    new_e;
  tbsa_pkg::in_item_t  it;
  tbsa_pkg::out_item_t out_next;

  logic [10:0] records_per_bin;
  logic        minute_mode;
  logic [10:0] bins_in_use;
  logic [10:0] dec_eff;
  logic [10:0] bins_eff;
  logic [15:0] dt_cfg;
  logic [15:0] dt;
  logic        records_seen;

  logic [tbsa_pkg::ADDR_W-1:0] clr_addr;
  logic [tbsa_pkg::ADDR_W-1:0] item_addr;
  logic [tbsa_pkg::ADDR_W-1:0] waddr;
  logic [tbsa_pkg::BIN_W-1:0]  bin_sel;
  logic                        we;
  logic                        ch_ok;

  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_busy;
  logic [127:0] prod;
  logic [51:0]  div_rem0;
  logic [63:0]  div_dvd;
  logic [51:0]  div_dvs;
  logic [6:0]   div_iters;
  logic         div_busy;
  logic [63:0]  quo;

  logic signed [40:0] p;
  logic [127:0]       a_reg;
  logic [127:0]       num;
  logic [51:0]        d;
  logic [63:0]        as_e;
  logic signed [23:0] mean;
  logic [23:0]        sd;

  logic [47:0] sq_v;
  logic [47:0] sq_res;
  logic [47:0] sq_bit;
  logic [47:0] sq_rb;
  logic [4:0]  sq_cnt;
  logic        sq_busy;

  logic        copy;
  logic [26:0] csum;
  logic [64:0] ws65;
  logic [64:0] sq65;
  logic        out_full;

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      records_per_bin <= 11'd1;
      minute_mode     <= 1'b1;
      bins_in_use     <= 11'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        tbsa_pkg::CFG_RPB:    records_per_bin <= cfg_data;
        tbsa_pkg::CFG_MINUTE: minute_mode     <= cfg_data[0];
        tbsa_pkg::CFG_BINS:   bins_in_use     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (records_per_bin == 11'd0) begin
      dec_eff = 11'd1;
    end else if (records_per_bin > 11'd1024) begin
      dec_eff = 11'd1024;
    end else begin
      dec_eff = records_per_bin;
    end
    bins_eff = (bins_in_use > 11'(tbsa_pkg::BINS)) ? 11'(tbsa_pkg::BINS) : bins_in_use;
    dt_cfg   = minute_mode ? ({5'b0, dec_eff} * 16'd60) : {5'b0, dec_eff};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it <= in_item;
      dt <= dt_cfg;
    end
  end

  // Store and its clearing pass.
  assign ch_ok     = 32'(it.channel) < tbsa_pkg::CHANNELS;
  assign bin_sel   = it.command ? it.bin_index : quo[tbsa_pkg::BIN_W-1:0];
  assign item_addr = {it.channel, bin_sel};
  assign we        = cmd.clr_step | cmd.wr_acc | cmd.wr_zero;
  assign waddr     = cmd.clr_step ? clr_addr : item_addr;
  assign wdata     = cmd.wr_acc ? new_e : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[item_addr];
    end
  end

  // Record merge.
  always_comb begin
    copy      = (dec_eff == 11'd1) || (rdata.cnt == 26'd0);
    new_e     = rdata;
    new_e.mn  = (copy || (it.min_in < rdata.mn)) ? it.min_in : rdata.mn;
    new_e.mx  = (copy || (it.max_in > rdata.mx)) ? it.max_in : rdata.mx;
    csum      = {1'b0, rdata.cnt} + {11'b0, it.count_in};
    new_e.cnt = (csum > {1'b0, tbsa_pkg::CNT_MAX}) ? tbsa_pkg::CNT_MAX : csum[25:0];
    ws65      = {rdata.wsum[63], rdata.wsum} + {{24{p[40]}}, p};
    if (ws65[64] != ws65[63]) begin
      new_e.wsum = ws65[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      new_e.wsum = ws65[63:0];
    end
    sq65        = {1'b0, rdata.sqsum} + {1'b0, prod[63:0]};
    new_e.sqsum = sq65[64] ? {64{1'b1}} : sq65[63:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.p_ld) begin
      p <= it.mean_in * $signed({1'b0, it.count_in});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      records_seen <= 1'b0;
    end else if (cmd.wr_acc) begin
      records_seen <= 1'b1;
    end
  end

  // Multiplier operands.
  assign as_e = rdata.wsum[63] ? 64'(-rdata.wsum) : 64'(rdata.wsum);

  always_comb begin
    case (cmd.mul_sel)
      tbsa_pkg::MUL_RR: begin
        mul_a = {40'b0, it.rms_in};
        mul_b = {40'b0, it.rms_in};
      end
      tbsa_pkg::MUL_RRN: begin
        mul_a = prod[63:0];
        mul_b = {48'b0, it.count_in};
      end
      tbsa_pkg::MUL_SQN: begin
        mul_a = rdata.sqsum;
        mul_b = {38'b0, rdata.cnt};
      end
      tbsa_pkg::MUL_SS: begin
        mul_a = as_e;
        mul_b = as_e;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tbsa_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.mul_start),
    .a_in (mul_a),
    .b_in (mul_b),
    .busy (mul_busy),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.a_ld) begin
      a_reg <= prod;
    end
    if (cmd.num_ld) begin
      num <= (a_reg >= prod) ? a_reg - prod : prod - a_reg;
      d   <= {26'b0, rdata.cnt} * {26'b0, rdata.cnt - 26'd1};
    end
  end

  // Divider operands.
  always_comb begin
    case (cmd.div_sel)
      tbsa_pkg::DIV_BIN: begin
        div_rem0  = '0;
        div_dvd   = {it.time_offset[30:0], 33'b0};
        div_dvs   = {36'b0, dt};
        div_iters = 7'd31;
      end
      tbsa_pkg::DIV_MEAN: begin
        div_rem0  = '0;
        div_dvd   = as_e + {39'b0, rdata.cnt[25:1]};
        div_dvs   = {26'b0, rdata.cnt};
        div_iters = 7'd64;
      end
      tbsa_pkg::DIV_SD: begin
        // The high part of the numerator is already known to be below d.
        div_rem0  = num[99:48];
        div_dvd   = {num[47:0], 16'b0};
        div_dvs   = d;
        div_iters = 7'd48;
      end
      default: begin
        div_rem0  = '0;
        div_dvd   = '0;
        div_dvs   = '0;
        div_iters = '0;
      end
    endcase
  end

  tbsa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .rem0  (div_rem0),
    .dvd0  (div_dvd),
    .dvs_in(div_dvs),
    .iters (div_iters),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.mean_ld) begin
      if (rdata.cnt == 26'd0) begin
        mean <= '0;
      end else if (rdata.wsum[63]) begin
        mean <= (quo > 64'd8388608) ? 24'sh800000 : $signed(24'(0 - quo[23:0]));
      end else begin
        mean <= (quo > 64'd8388607) ? 24'sh7FFFFF : $signed(quo[23:0]);
      end
    end
  end

  // Integer square root, one result bit per cycle.
  assign sq_rb = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_cnt  <= '0;
    end else if (cmd.sqrt_start) begin
      sq_busy <= 1'b1;
      sq_cnt  <= 5'd24;
    end else if (sq_busy) begin
      sq_cnt <= sq_cnt - 5'd1;
      if (sq_cnt == 5'd1) begin
        sq_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_v   <= quo[47:0];
      sq_res <= '0;
      sq_bit <= 48'h4000_0000_0000;
    end else if (sq_busy) begin
      if (sq_v >= sq_rb) begin
        sq_v   <= sq_v - sq_rb;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sd_ld) begin
      case (cmd.sd_sel)
        tbsa_pkg::SD_ZERO: sd <= '0;
        tbsa_pkg::SD_SAT:  sd <= 24'hFFFFFF;
        tbsa_pkg::SD_ROOT: sd <= sq_res[23:0];
        default:           sd <= '0;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.out_load) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_comb begin
    out_next          = '0;
    out_next.status   = cmd.out_status;
    out_next.any_data = records_seen | cmd.wr_acc;
    if (cmd.out_status == tbsa_pkg::ST_READ) begin
      out_next.bin_time     = {10'b0, dt} * {16'b0, it.bin_index};
      out_next.sample_count = rdata.cnt;
      out_next.mean_out     = mean;
      out_next.std_dev_out  = sd;
      out_next.minimum_out  = rdata.mn;
      out_next.maximum_out  = rdata.mx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item <= out_next;
    end
  end

  assign out_valid = out_full;

  assign st.clr_done  = clr_addr == tbsa_pkg::ADDR_W'(tbsa_pkg::DEPTH - 1);
  assign st.div_busy  = div_busy;
  assign st.mul_busy  = mul_busy;
  assign st.sqrt_busy = sq_busy;
  assign st.in_range  = ch_ok && !it.time_offset[31] && (quo < {53'b0, bins_eff});
  assign st.rd_ok     = ch_ok && ({1'b0, it.bin_index} < bins_eff);
  assign st.n_lt2     = rdata.cnt < 26'd2;
  assign st.sd_sat    = num[127:48] >= {28'b0, d};
  assign st.out_free  = !out_full || out_ready;

endmodule

// ----- rtl/tbsa_ctrl.sv -----
module tbsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  input  tbsa_pkg::dp_stat_t  st,
  output tbsa_pkg::ctrl_cmd_t cmd
);

  tbsa_pkg::state_t state;
  tbsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbsa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      tbsa_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) begin
          state_next = tbsa_pkg::S_IDLE;
        end
      end
      tbsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = in_command ? tbsa_pkg::S_RCHK : tbsa_pkg::S_BDIV;
        end
      end
      tbsa_pkg::S_BDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tbsa_pkg::DIV_BIN;
        state_next    = tbsa_pkg::S_BWAIT;
      end
      tbsa_pkg::S_BWAIT: begin
        if (!st.div_busy) begin
          state_next = tbsa_pkg::S_ACHK;
        end
      end
      tbsa_pkg::S_ACHK: begin
        if (st.in_range) begin
          cmd.mem_rd    = 1'b1;
          cmd.p_ld      = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = tbsa_pkg::MUL_RR;
          state_next    = tbsa_pkg::S_AM1W;
        end else begin
          state_next = tbsa_pkg::S_FIN_DROP;
        end
      end
      tbsa_pkg::S_AM1W: begin
        if (!st.mul_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = tbsa_pkg::MUL_RRN;
          state_next    = tbsa_pkg::S_AM2W;
        end
      end
      tbsa_pkg::S_AM2W: begin
        if (!st.mul_busy) begin
          cmd.wr_acc = 1'b1;
          state_next = tbsa_pkg::S_FIN_ACC;
        end
      end
      tbsa_pkg::S_RCHK: begin
        if (st.rd_ok) begin
          cmd.mem_rd = 1'b1;
          state_next = tbsa_pkg::S_RCLR;
        end else begin
          state_next = tbsa_pkg::S_FIN_DROP;
        end
      end
      tbsa_pkg::S_RCLR: begin
        // The read data register keeps the old entry while the bin is cleared.
        cmd.wr_zero   = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = tbsa_pkg::MUL_SQN;
        state_next    = tbsa_pkg::S_RMAW;
      end
      tbsa_pkg::S_RMAW: begin
        if (!st.mul_busy) begin
          cmd.a_ld      = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = tbsa_pkg::MUL_SS;
          state_next    = tbsa_pkg::S_RMBW;
        end
      end
      tbsa_pkg::S_RMBW: begin
        if (!st.mul_busy) begin
          cmd.num_ld    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = tbsa_pkg::DIV_MEAN;
          state_next    = tbsa_pkg::S_RMDW;
        end
      end
      tbsa_pkg::S_RMDW: begin
        if (!st.div_busy) begin
          cmd.mean_ld = 1'b1;
          if (st.n_lt2) begin
            cmd.sd_ld  = 1'b1;
            cmd.sd_sel = tbsa_pkg::SD_ZERO;
            state_next = tbsa_pkg::S_FIN_READ;
          end else if (st.sd_sat) begin
            cmd.sd_ld  = 1'b1;
            cmd.sd_sel = tbsa_pkg::SD_SAT;
            state_next = tbsa_pkg::S_FIN_READ;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = tbsa_pkg::DIV_SD;
            state_next    = tbsa_pkg::S_RSDW;
          end
        end
      end
      tbsa_pkg::S_RSDW: begin
        if (!st.div_busy) begin
          cmd.sqrt_start = 1'b1;
          state_next     = tbsa_pkg::S_RSQW;
        end
      end
      tbsa_pkg::S_RSQW: begin
        if (!st.sqrt_busy) begin
          cmd.sd_ld  = 1'b1;
          cmd.sd_sel = tbsa_pkg::SD_ROOT;
          state_next = tbsa_pkg::S_FIN_READ;
        end
      end
      tbsa_pkg::S_FIN_ACC: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = tbsa_pkg::ST_ACC;
          state_next     = tbsa_pkg::S_IDLE;
        end
      end
      tbsa_pkg::S_FIN_DROP: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = tbsa_pkg::ST_DROP;
          state_next     = tbsa_pkg::S_IDLE;
        end
      end
      tbsa_pkg::S_FIN_READ: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = tbsa_pkg::ST_READ;
          state_next     = tbsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tbsa_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !st.div_busy)
    else $error("divider started while busy");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !st.mul_busy)
    else $error("multiplier started while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result register overwritten before it was taken");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != tbsa_pkg::S_IDLE))
    else $error("item accepted but controller stayed idle");
`endif

endmodule

// ----- rtl/trend_bin_statistics_aggregator_core.sv -----
// A record is taken through a bin divide and two multiplies before its result is
// given; a dropped record stops after the divide. A bin read runs two 64x64
// multiplies, a mean divide, a variance divide and a square root, and skips the
// last two when the bin has under two samples or the deviation saturates.
// One item is in work at a time; the next is taken once the last result is loaded.
// Reset is synchronous; a clearing pass then zeroes the store.
module trend_bin_statistics_aggregator_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tbsa_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tbsa_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [10:0]         cfg_data
);

  tbsa_pkg::ctrl_cmd_t cmd;
  tbsa_pkg::dp_stat_t  st;

  assign cfg_ready = 1'b1;

  tbsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_command(in_item.command),
    .in_ready  (in_ready),
    .st        (st),
    .cmd       (cmd)
  );

  tbsa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .in_item  (in_item),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

// ----- bench/trend_bin_statistics_aggregator_core_tb.sv -----
`timescale 1ns / 100ps

module trend_bin_statistics_aggregator_core_tb;

  localparam int PERIOD = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tbsa_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tbsa_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;

  trend_bin_statistics_aggregator_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #(PERIOD / 2) clk = 1'b1;
    #(PERIOD / 2) clk = 1'b0;
  end

  // Predictor state: a copy of the bin store and the registers.
  logic [10:0] rpb_reg, bins_reg;
  logic minute_reg;
  logic [25:0] cnt_store [tbsa_pkg::DEPTH];
  logic signed [63:0] wsum_store [tbsa_pkg::DEPTH];
  logic [63:0] sq_store [tbsa_pkg::DEPTH];
  logic signed [23:0] mn_store [tbsa_pkg::DEPTH];
  logic signed [23:0] mx_store [tbsa_pkg::DEPTH];
  logic seen_any;

  tbsa_pkg::in_item_t pending_items[$];
  tbsa_pkg::out_item_t expected_results[$];
  int errors = 0;
  int n_acc = 0, n_drop = 0, n_read = 0;
  bit hold_input = 1'b0;

  function automatic logic [23:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 46;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res[23:0];
  endfunction

  function automatic logic [23:0] bin_std_dev(logic [25:0] n, logic signed [63:0] s,
                                              logic [63:0] sq);
    logic [127:0] a, b, num, q;
    logic [63:0] mag, d;
    if (n < 2) return 24'd0;
    mag = s < 0 ? -s : s;
    a = {64'd0, sq} * {102'd0, n};
    b = {64'd0, mag} * {64'd0, mag};
    num = a >= b ? a - b : b - a;
    d = {38'd0, n} * {38'd0, n - 26'd1};
    if (num >= ({64'd0, d} << 48)) return 24'hFFFFFF;
    q = num / {64'd0, d};
    return int_sqrt(q[63:0]);
  endfunction

  function automatic logic signed [23:0] bin_mean(logic [25:0] n, logic signed [63:0] s);
    logic [63:0] mag, q;
    if (n == 0) return 24'sd0;
    mag = s < 0 ? -s : s;
    q = (mag + {39'd0, n[25:1]}) / {38'd0, n};
    if (s < 0) return q > 64'd8388608 ? -24'sd8388608 : -q[23:0];
    return q > 64'd8388607 ? 24'sd8388607 : q[23:0];
  endfunction

  function automatic tbsa_pkg::out_item_t predict_bin_step(tbsa_pkg::in_item_t it);
    tbsa_pkg::out_item_t r;
    logic [31:0] dec, nb, dt, bi;
    logic [12:0] k;
    logic signed [63:0] p, w;
    logic [63:0] add, rr;
    r = '0;
    r.status = tbsa_pkg::ST_DROP;
    dec = rpb_reg == 0 ? 1 : (rpb_reg > 1024 ? 1024 : rpb_reg);
    nb = bins_reg > tbsa_pkg::BINS ? tbsa_pkg::BINS : bins_reg;
    dt = dec * (minute_reg ? 60 : 1);
    if (it.command == 1'b0) begin
      if (it.time_offset >= 0 && ($unsigned(it.time_offset) / dt) < nb) begin
        bi = $unsigned(it.time_offset) / dt;
        k = {it.channel, bi[9:0]};
        if (dec == 1 || cnt_store[k] == 0) begin
          mn_store[k] = it.min_in;
          mx_store[k] = it.max_in;
        end else begin
          if (it.min_in < mn_store[k]) mn_store[k] = it.min_in;
          if (it.max_in > mx_store[k]) mx_store[k] = it.max_in;
        end
        cnt_store[k] = (tbsa_pkg::CNT_MAX - cnt_store[k] < it.count_in) ? tbsa_pkg::CNT_MAX
                                                                  : cnt_store[k] + it.count_in;
        p = 64'(it.mean_in) * $signed({48'd0, it.count_in});
        w = wsum_store[k];
        if (p > 0 && w > 64'sh7FFFFFFFFFFFFFFF - p) wsum_store[k] = 64'sh7FFFFFFFFFFFFFFF;
        else if (p < 0 && w < -64'sh7FFFFFFFFFFFFFFF - 1 - p)
          wsum_store[k] = 64'sh8000000000000000;
        else wsum_store[k] = w + p;
        rr = {40'd0, it.rms_in};
        add = rr * rr * {48'd0, it.count_in};
        sq_store[k] = (64'hFFFFFFFFFFFFFFFF - sq_store[k] < add) ? 64'hFFFFFFFFFFFFFFFF
                                                                 : sq_store[k] + add;
        seen_any = 1'b1;
        r.status = tbsa_pkg::ST_ACC;
      end
    end else if (it.bin_index < nb) begin
      k = {it.channel, it.bin_index};
      r.status = tbsa_pkg::ST_READ;
      r.bin_time = 26'(dt * it.bin_index);
      r.sample_count = cnt_store[k];
      r.mean_out = bin_mean(cnt_store[k], wsum_store[k]);
      r.std_dev_out = bin_std_dev(cnt_store[k], wsum_store[k], sq_store[k]);
      r.minimum_out = mn_store[k];
      r.maximum_out = mx_store[k];
      cnt_store[k] = 0;
      wsum_store[k] = 0;
      sq_store[k] = 0;
      mn_store[k] = 0;
      mx_store[k] = 0;
    end
    r.any_data = seen_any;
    return r;
  endfunction

  // Sender: bursts of items with random gaps in between.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), predict_bin_step(in_item));
        void'(pending_items.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold the item until accepted
      end else if (gap_left > 0 || hold_input || pending_items.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_item <= pending_items[0];
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stalls in a pattern of its own, with quiet stretches.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[9]) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
  end

  always @(posedge clk) begin
    tbsa_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        errors++;
      end else begin
        e = expected_results.pop_front();
        case (e.status)
          tbsa_pkg::ST_ACC: n_acc++;
          tbsa_pkg::ST_DROP: n_drop++;
          default: n_read++;
        endcase
        if (out_item.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_item.status); errors++;
        end
        if (out_item.bin_time !== e.bin_time) begin
          $error("bin_time expected %0d actual %0d", e.bin_time, out_item.bin_time);
          errors++;
        end
        if (out_item.sample_count !== e.sample_count) begin
          $error("sample_count expected %0d actual %0d", e.sample_count,
                 out_item.sample_count);
          errors++;
        end
        if (out_item.mean_out !== e.mean_out) begin
          $error("mean_out expected %0d actual %0d", e.mean_out, out_item.mean_out);
          errors++;
        end
        if (out_item.std_dev_out !== e.std_dev_out) begin
          $error("std_dev_out expected %0d actual %0d", e.std_dev_out,
                 out_item.std_dev_out);
          errors++;
        end
        if (out_item.minimum_out !== e.minimum_out) begin
          $error("minimum_out expected %0d actual %0d", e.minimum_out,
                 out_item.minimum_out);
          errors++;
        end
        if (out_item.maximum_out !== e.maximum_out) begin
          $error("maximum_out expected %0d actual %0d", e.maximum_out,
                 out_item.maximum_out);
          errors++;
        end
        if (out_item.any_data !== e.any_data) begin
          $error("any_data expected %0d actual %0d", e.any_data, out_item.any_data);
          errors++;
        end
      end
    end
  end

  task automatic drain_all();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      tbsa_pkg::CFG_RPB: rpb_reg = val;
      tbsa_pkg::CFG_MINUTE: minute_reg = val[0];
      tbsa_pkg::CFG_BINS: bins_reg = val;
      default: ;
    endcase
  endtask

  function automatic logic signed [23:0] rand_q24();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom_range(0, 4000)) - 24'sd2000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Records are mostly well placed in a few hot bins so reads see merged data.
  function automatic tbsa_pkg::in_item_t rand_record(logic [31:0] dt, logic [10:0] nb);
    tbsa_pkg::in_item_t it;
    logic signed [23:0] a, b;
    it = '0;
    it.command = 1'b0;
    it.channel = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) it.time_offset = $urandom;
    else it.time_offset = 32'($urandom_range(0, 5) * dt + $urandom_range(0, dt - 1));
    it.bin_index = 10'($urandom);
    it.count_in = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    it.mean_in = rand_q24();
    it.rms_in = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
    a = rand_q24();
    b = rand_q24();
    it.min_in = a < b ? a : b;
    it.max_in = a < b ? b : a;
    if (nb == 0) it.time_offset = 32'($urandom_range(0, 100));
    return it;
  endfunction

  function automatic tbsa_pkg::in_item_t rand_read();
    tbsa_pkg::in_item_t it;
    it = '0;
    it.command = 1'b1;
    it.channel = 3'($urandom_range(0, 7));
    it.bin_index = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 6));
    it.time_offset = $urandom;
    it.count_in = 16'($urandom);
    it.mean_in = 24'($urandom);
    it.rms_in = 24'($urandom);
    it.min_in = 24'($urandom);
    it.max_in = 24'($urandom);
    return it;
  endfunction

  task automatic random_phase(int n);
    logic [31:0] dt;
    dt = (rpb_reg == 0 ? 1 : rpb_reg) * (minute_reg ? 60 : 1);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) pending_items.insert(pending_items.size(), rand_read());
      else pending_items.insert(pending_items.size(), rand_record(dt, bins_reg));
    end
  endtask

  initial begin
    tbsa_pkg::in_item_t it;
    rpb_reg = 1;
    minute_reg = 1'b1;
    bins_reg = 1024;
    seen_any = 1'b0;
    for (int i = 0; i < tbsa_pkg::DEPTH; i++) begin
      cnt_store[i] = 0; wsum_store[i] = 0; sq_store[i] = 0;
      mn_store[i] = 0; mx_store[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a read before any record, extremes, negative and far offsets.
    it = '0; it.command = 1'b1; it.channel = 3'd7; it.bin_index = 10'd1023;
    pending_items.insert(pending_items.size(), it);
    it = '0; it.time_offset = -32'sd1; it.count_in = 16'hFFFF;
    pending_items.insert(pending_items.size(), it);
    it = '0; it.time_offset = 32'sh7FFFFFFF; pending_items.insert(pending_items.size(), it);
    it = '0; it.time_offset = 32'sh80000000; pending_items.insert(pending_items.size(), it);
    it = '0; it.time_offset = 32'sd61439; it.channel = 3'd7; it.count_in = 16'hFFFF;
    it.mean_in = 24'sh7FFFFF; it.rms_in = 24'hFFFFFF;
    it.min_in = 24'sh800000; it.max_in = 24'sh7FFFFF;
    pending_items.insert(pending_items.size(), it);
    it.time_offset = 32'sd61440; pending_items.insert(pending_items.size(), it);
    it = '0; it.command = 1'b1; it.channel = 3'd7; it.bin_index = 10'd1023;
    pending_items.insert(pending_items.size(), it);
    it = '0; it.count_in = 16'd1; it.mean_in = -24'sd300; it.rms_in = 24'd300;
    it.min_in = -24'sd400; it.max_in = -24'sd200;
    pending_items.insert(pending_items.size(), it);
    it.count_in = 16'd0; pending_items.insert(pending_items.size(), it);
    it = '0; it.command = 1'b1; pending_items.insert(pending_items.size(), it);
    pending_items.insert(pending_items.size(), it);
    drain_all();

    // Decimation with merging, second trends, saturating sums.
    write_reg(tbsa_pkg::CFG_RPB, 11'd4);
    write_reg(tbsa_pkg::CFG_MINUTE, 11'd0);
    write_reg(tbsa_pkg::CFG_BINS, 11'd8);
    for (int i = 0; i < 4; i++) begin
      it = '0; it.channel = 3'd2; it.time_offset = i; it.count_in = 16'hFFFF;
      it.mean_in = i[0] ? 24'sh800000 : 24'sh7FFFFF; it.rms_in = 24'hFFFFFF;
      it.min_in = 24'(-i * 10); it.max_in = 24'(i * 10);
      pending_items.insert(pending_items.size(), it);
    end
    it = '0; it.command = 1'b1; it.channel = 3'd2; pending_items.insert(pending_items.size(), it);
    it.bin_index = 10'd8; pending_items.insert(pending_items.size(), it);
    random_phase(150);
    hold_input = 1'b0;
    drain_all();

    write_reg(tbsa_pkg::CFG_RPB, 11'd0);
    write_reg(tbsa_pkg::CFG_BINS, 11'd0);
    random_phase(60);
    drain_all();

    write_reg(tbsa_pkg::CFG_RPB, 11'd2047);
    write_reg(tbsa_pkg::CFG_MINUTE, 11'd1);
    write_reg(tbsa_pkg::CFG_BINS, 11'd2047);
    random_phase(100);
    drain_all();

    write_reg(tbsa_pkg::CFG_RPB, 11'd1);
    write_reg(tbsa_pkg::CFG_BINS, 11'd6);
    random_phase(250);
    drain_all();

    write_reg(tbsa_pkg::CFG_RPB, 11'd3);
    write_reg(tbsa_pkg::CFG_MINUTE, 11'd0);
    write_reg(tbsa_pkg::CFG_BINS, 11'd1);
    random_phase(240);
    drain_all();

    $display("Covered %0d accumulated, %0d dropped and %0d read-out items", n_acc, n_drop,
             n_read);
    $display("over six register settings including the extremes.");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Pause the sender once mid-run until the block has caught up.
  initial begin
    wait (!rst);
    wait (n_acc + n_drop + n_read > 60);
    hold_input = 1'b1;
    @(posedge clk);
    while (expected_results.size() != 0 || in_valid) @(posedge clk);
    hold_input = 1'b0;
  end

  initial begin
    #(PERIOD * 3000000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
